// ===== rtl/plu_pkg.sv =====
// shared types, constants and helpers for the polyline linear upsampler
`default_nettype none
package plu_pkg;

    localparam int COORD_W = 32;
    localparam int CNT_W   = 7;
    localparam int DIV_W   = COORD_W + 1;
    localparam int DIVS_W  = 7;

    localparam logic [CNT_W-1:0] MAX_POINTS = CNT_W'(64);

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_TARGET_COUNT = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      inserted;
        logic                      last_of_run;
        logic                      bad_size;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TOT_WAIT,
        ST_SEG_START,
        ST_SEG_WAIT,
        ST_EMIT_ONE,
        ST_EMIT_HELD,
        ST_EMIT_INS,
        ST_EMIT_CUR
    } t_state;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_BAD,
        EM_PASS,
        EM_HELD,
        EM_INS,
        EM_CUR
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  hold_first;
        logic  tot_start;
        logic  tot_load;
        logic  seg_start;
        logic  seg_load;
        logic  step;
        logic  commit;
        t_emit emit;
        logic  last_of_run;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic pass;
        logic first;
        logic k_zero;
        logic j_at_k;
        logic last;
        logic tot_done;
        logic seg_done;
        logic slot_free;
    } t_dp_status;

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        return (v > MAX_POINTS) ? MAX_POINTS : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/plu_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module plu_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [plu_pkg::DIV_W-1:0]         i_dividend,
    input  wire logic [plu_pkg::DIVS_W-1:0]        i_divisor,
    output logic                                   o_done,
    output logic      [plu_pkg::DIV_W-1:0]         o_quotient,
    output logic      [plu_pkg::DIVS_W-1:0]        o_remainder
);

    localparam int CW = $clog2(plu_pkg::DIV_W + 1);

    logic [plu_pkg::DIV_W-1:0]  r_quo;
    logic [plu_pkg::DIVS_W-1:0] r_rem;
    logic [plu_pkg::DIVS_W-1:0] r_dvs;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [plu_pkg::DIVS_W:0]   w_trial;
    logic [plu_pkg::DIVS_W:0]   w_diff;
    logic                       w_ge;
    logic [plu_pkg::DIVS_W-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[plu_pkg::DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_ge ? w_diff[plu_pkg::DIVS_W-1:0] : w_trial[plu_pkg::DIVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(plu_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[plu_pkg::DIV_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

// ===== rtl/plu_datapath.sv =====
// vertex state, division units, point stepping and result register
`default_nettype none
module plu_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [plu_pkg::CNT_W-1:0]       i_vertex_count,
    input  wire logic [plu_pkg::CNT_W-1:0]       i_target_count,
    input  wire plu_pkg::t_in_item               i_in_data,
    input  wire logic                            i_out_ready,
    input  wire plu_pkg::t_dp_cmd                i_cmd,
    output plu_pkg::t_dp_status                  o_status,
    output logic                                 o_out_valid,
    output plu_pkg::t_out_item                   o_out_data
);

    localparam int CW = plu_pkg::CNT_W;
    localparam int DW = plu_pkg::DIV_W;
    localparam int SW = plu_pkg::DIVS_W;
    localparam int XW = plu_pkg::COORD_W;

    // vertex state
    logic [XW-1:0]       r_held_x;
    logic [XW-1:0]       r_held_y;
    logic [CW-1:0]       r_vi;
    logic [CW-1:0]       r_isf;

    // per request work
    plu_pkg::t_in_item   r_cur;
    logic [CW-1:0]       r_k;
    logic                r_last;
    logic                r_neg_x;
    logic                r_neg_y;
    logic [DW-1:0]       r_base_x;
    logic [DW-1:0]       r_base_y;
    logic [SW-1:0]       r_rm_x;
    logic [SW-1:0]       r_rm_y;
    logic [DW-1:0]       r_qx;
    logic [DW-1:0]       r_qy;
    logic [SW-1:0]       r_rx;
    logic [SW-1:0]       r_ry;
    logic [CW-1:0]       r_j;

    logic                r_out_valid;
    plu_pkg::t_out_item  r_out;

    logic [CW-1:0]       w_n;
    logic [CW-1:0]       w_s;
    logic [CW-1:0]       w_nm1;
    logic                w_last_now;
    logic [CW-1:0]       w_isel;
    logic [CW-1:0]       w_span;
    logic [2*CW-1:0]     w_prod;
    logic [CW-1:0]       w_total;
    logic [SW-1:0]       w_kp1;
    logic [DW-1:0]       w_dx;
    logic [DW-1:0]       w_dy;
    logic [DW-1:0]       w_absx;
    logic [DW-1:0]       w_absy;
    logic [SW:0]         w_rsum_x;
    logic [SW:0]         w_rsum_y;
    logic                w_wrap_x;
    logic                w_wrap_y;
    logic [SW-1:0]       n_rx;
    logic [SW-1:0]       n_ry;
    logic [DW-1:0]       n_qx;
    logic [DW-1:0]       n_qy;
    logic [DW-1:0]       w_ins_x;
    logic [DW-1:0]       w_ins_y;
    logic                w_slot_free;
    plu_pkg::t_out_item  n_out;

    logic                w_start_x;
    logic [DW-1:0]       w_dvd_x;
    logic [SW-1:0]       w_dvs_x;
    logic                w_done_x;
    logic [DW-1:0]       w_quo_x;
    logic [SW-1:0]       w_rem_x;
    logic                w_done_y;
    logic [DW-1:0]       w_quo_y;
    logic [SW-1:0]       w_rem_y;

    assign w_n        = plu_pkg::sat_count(i_vertex_count);
    assign w_s        = plu_pkg::sat_count(i_target_count);
    assign w_nm1      = w_n - CW'(1);
    assign w_last_now = (r_vi >= w_nm1);
    assign w_isel     = w_last_now ? w_nm1 : r_vi;
    assign w_span     = w_s - w_n;
    assign w_prod     = (2*CW)'(w_isel) * (2*CW)'(w_span);
    assign w_total    = w_quo_x[CW-1:0];
    assign w_kp1      = SW'(r_k) + SW'(1);

    assign w_dx   = {r_cur.coord_x[XW-1], r_cur.coord_x} - {r_held_x[XW-1], r_held_x};
    assign w_dy   = {r_cur.coord_y[XW-1], r_cur.coord_y} - {r_held_y[XW-1], r_held_y};
    assign w_absx = w_dx[DW-1] ? (DW'(0) - w_dx) : w_dx;
    assign w_absy = w_dy[DW-1] ? (DW'(0) - w_dy) : w_dy;

    assign w_start_x = i_cmd.tot_start | i_cmd.seg_start;
    assign w_dvd_x   = i_cmd.tot_start ? DW'(w_prod) : w_absx;
    assign w_dvs_x   = i_cmd.tot_start ? SW'(w_nm1) : w_kp1;

    plu_div u_div_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start_x),
        .i_dividend  (w_dvd_x),
        .i_divisor   (w_dvs_x),
        .o_done      (w_done_x),
        .o_quotient  (w_quo_x),
        .o_remainder (w_rem_x)
    );

    plu_div u_div_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.seg_start),
        .i_dividend  (w_absy),
        .i_divisor   (w_kp1),
        .o_done      (w_done_y),
        .o_quotient  (w_quo_y),
        .o_remainder (w_rem_y)
    );

    // running quotient of |d|*j/(k+1)
    assign w_rsum_x = {1'b0, r_rx} + {1'b0, r_rm_x};
    assign w_rsum_y = {1'b0, r_ry} + {1'b0, r_rm_y};
    assign w_wrap_x = (w_rsum_x >= {1'b0, w_kp1});
    assign w_wrap_y = (w_rsum_y >= {1'b0, w_kp1});
    assign n_rx     = w_wrap_x ? SW'(w_rsum_x - {1'b0, w_kp1}) : w_rsum_x[SW-1:0];
    assign n_ry     = w_wrap_y ? SW'(w_rsum_y - {1'b0, w_kp1}) : w_rsum_y[SW-1:0];
    assign n_qx     = r_qx + r_base_x + DW'(w_wrap_x);
    assign n_qy     = r_qy + r_base_y + DW'(w_wrap_y);

    assign w_ins_x = {r_held_x[XW-1], r_held_x} + (r_neg_x ? (DW'(0) - r_qx) : r_qx);
    assign w_ins_y = {r_held_y[XW-1], r_held_y} + (r_neg_y ? (DW'(0) - r_qy) : r_qy);

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out             = '0;
        n_out.last_of_run = i_cmd.last_of_run;
        case (i_cmd.emit)
            plu_pkg::EM_BAD: begin
                n_out.bad_size = 1'b1;
            end
            plu_pkg::EM_PASS, plu_pkg::EM_CUR: begin
                n_out.out_x = r_cur.coord_x;
                n_out.out_y = r_cur.coord_y;
            end
            plu_pkg::EM_HELD: begin
                n_out.out_x = r_held_x;
                n_out.out_y = r_held_y;
            end
            plu_pkg::EM_INS: begin
                n_out.out_x    = w_ins_x[XW-1:0];
                n_out.out_y    = w_ins_y[XW-1:0];
                n_out.inserted = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // control state and vertex state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_vi        <= '0;
            r_isf       <= '0;
        end else begin
            if (i_cmd.emit != plu_pkg::EM_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.hold_first) begin
                r_held_x <= r_cur.coord_x;
                r_held_y <= r_cur.coord_y;
                r_vi     <= CW'(1);
                r_isf    <= '0;
            end else if (i_cmd.commit) begin
                if (r_last) begin
                    r_vi  <= '0;
                    r_isf <= '0;
                end else begin
                    r_held_x <= r_cur.coord_x;
                    r_held_y <= r_cur.coord_y;
                    r_vi     <= r_vi + CW'(1);
                    r_isf    <= r_isf + r_k;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != plu_pkg::EM_NONE) begin
            r_out <= n_out;
        end
        if (i_cmd.capture) begin
            r_cur <= i_in_data;
        end
        if (i_cmd.tot_load) begin
            r_k    <= (w_total > r_isf) ? (w_total - r_isf) : '0;
            r_last <= w_last_now;
        end
        if (i_cmd.seg_start) begin
            r_neg_x <= w_dx[DW-1];
            r_neg_y <= w_dy[DW-1];
        end
        if (i_cmd.seg_load) begin
            r_base_x <= w_quo_x;
            r_base_y <= w_quo_y;
            r_rm_x   <= w_rem_x;
            r_rm_y   <= w_rem_y;
            r_qx     <= '0;
            r_qy     <= '0;
            r_rx     <= '0;
            r_ry     <= '0;
            r_j      <= '0;
        end else if (i_cmd.step) begin
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_j  <= r_j + CW'(1);
        end
    end

    always_comb begin
        o_status.bad       = (w_s < w_n);
        o_status.pass      = (w_n < CW'(2));
        o_status.first     = (r_vi == '0);
        o_status.k_zero    = (r_k == '0);
        o_status.j_at_k    = (r_j == r_k);
        o_status.last      = r_last;
        o_status.tot_done  = w_done_x;
        o_status.seg_done  = w_done_x & w_done_y;
        o_status.slot_free = w_slot_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== rtl/plu_ctrl.sv =====
// sequencing state machine for the upsampler
`default_nettype none
module plu_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire plu_pkg::t_dp_status   i_status,
    output logic                       o_in_ready,
    output plu_pkg::t_dp_cmd           o_cmd
);

    plu_pkg::t_state r_state;
    plu_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            plu_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = plu_pkg::ST_CHECK;
            end
            plu_pkg::ST_CHECK: begin
                if (i_status.bad || i_status.pass) n_state = plu_pkg::ST_EMIT_ONE;
                else if (i_status.first)           n_state = plu_pkg::ST_IDLE;
                else                               n_state = plu_pkg::ST_TOT_WAIT;
            end
            plu_pkg::ST_TOT_WAIT: begin
                if (i_status.tot_done) n_state = plu_pkg::ST_SEG_START;
            end
            plu_pkg::ST_SEG_START: begin
                if (i_status.k_zero) n_state = plu_pkg::ST_EMIT_HELD;
                else                 n_state = plu_pkg::ST_SEG_WAIT;
            end
            plu_pkg::ST_SEG_WAIT: begin
                if (i_status.seg_done) n_state = plu_pkg::ST_EMIT_HELD;
            end
            plu_pkg::ST_EMIT_ONE: begin
                if (i_status.slot_free) n_state = plu_pkg::ST_IDLE;
            end
            plu_pkg::ST_EMIT_HELD: begin
                if (i_status.slot_free) begin
                    if (!i_status.k_zero)    n_state = plu_pkg::ST_EMIT_INS;
                    else if (i_status.last)  n_state = plu_pkg::ST_EMIT_CUR;
                    else                     n_state = plu_pkg::ST_IDLE;
                end
            end
            plu_pkg::ST_EMIT_INS: begin
                if (i_status.slot_free && i_status.j_at_k) begin
                    if (i_status.last) n_state = plu_pkg::ST_EMIT_CUR;
                    else               n_state = plu_pkg::ST_IDLE;
                end
            end
            plu_pkg::ST_EMIT_CUR: begin
                if (i_status.slot_free) n_state = plu_pkg::ST_IDLE;
            end
            default: begin
                n_state = plu_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.emit = plu_pkg::EM_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            plu_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            plu_pkg::ST_CHECK: begin
                if (!i_status.bad && !i_status.pass) begin
                    o_cmd.hold_first = i_status.first;
                    o_cmd.tot_start  = !i_status.first;
                end
            end
            plu_pkg::ST_TOT_WAIT: begin
                o_cmd.tot_load = i_status.tot_done;
            end
            plu_pkg::ST_SEG_START: begin
                o_cmd.seg_start = !i_status.k_zero;
            end
            plu_pkg::ST_SEG_WAIT: begin
                o_cmd.seg_load = i_status.seg_done;
            end
            plu_pkg::ST_EMIT_ONE: begin
                if (i_status.slot_free) begin
                    o_cmd.emit        = i_status.bad ? plu_pkg::EM_BAD : plu_pkg::EM_PASS;
                    o_cmd.last_of_run = 1'b1;
                end
            end
            plu_pkg::ST_EMIT_HELD: begin
                if (i_status.slot_free) begin
                    o_cmd.emit        = plu_pkg::EM_HELD;
                    o_cmd.step        = 1'b1;
                    o_cmd.last_of_run = i_status.k_zero && !i_status.last;
                    o_cmd.commit      = i_status.k_zero && !i_status.last;
                end
            end
            plu_pkg::ST_EMIT_INS: begin
                if (i_status.slot_free) begin
                    o_cmd.emit        = plu_pkg::EM_INS;
                    o_cmd.step        = 1'b1;
                    o_cmd.last_of_run = i_status.j_at_k && !i_status.last;
                    o_cmd.commit      = i_status.j_at_k && !i_status.last;
                end
            end
            plu_pkg::ST_EMIT_CUR: begin
                if (i_status.slot_free) begin
                    o_cmd.emit        = plu_pkg::EM_CUR;
                    o_cmd.last_of_run = 1'b1;
                    o_cmd.commit      = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/polyline_linear_upsampler.sv =====
// top level: register port, controller and datapath of the polyline upsampler
// one request at a time; a first vertex, a pass-through or a size error uses no divider
// a segment vertex emits the held vertex and k inserted points, and the current vertex as well
// on the last vertex; the total and the step each wait on a divider
// results wait in an output register, so the next request is taken while one is pending
// synchronous active-low reset clears the count registers, the vertex state and the output valid
`default_nettype none
module polyline_linear_upsampler (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire plu_pkg::t_in_item     i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output plu_pkg::t_out_item         o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    logic [plu_pkg::CNT_W-1:0] r_vertex_count;
    logic [plu_pkg::CNT_W-1:0] r_target_count;
    logic                      w_wr;

    plu_pkg::t_dp_cmd          w_cmd;
    plu_pkg::t_dp_status       w_status;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_target_count <= '0;
        end else if (w_wr) begin
            case (paddr[2])
                plu_pkg::REG_VERTEX_COUNT: r_vertex_count <= pwdata[plu_pkg::CNT_W-1:0];
                plu_pkg::REG_TARGET_COUNT: r_target_count <= pwdata[plu_pkg::CNT_W-1:0];
                default: begin
                    r_vertex_count <= r_vertex_count;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            plu_pkg::REG_VERTEX_COUNT: prdata = 32'(r_vertex_count);
            plu_pkg::REG_TARGET_COUNT: prdata = 32'(r_target_count);
            default:                   prdata = '0;
        endcase
    end

    plu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    plu_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .i_target_count (r_target_count),
        .i_in_data      (i_in_data),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

endmodule
`default_nettype wire
